[design/srd_pkg.sv]
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for the signed restoring divider
// Holds the default operand width and the flags that travel down the pipe.
// ----------------------------------------------------------------------------
package srd_pkg;

	// default operand width
	localparam int WIDTH_DEF = 32;

	// per-word side information carried through the iteration stages
	typedef struct packed {
		logic neg;   // operand signs differ: negate the magnitude quotient
		logic sat;   // zero divisor or most-negative over minus one
	} srd_flags_t;

endpackage

[design/srd_stage.sv]
// ----------------------------------------------------------------------------
// srd_stage: one registered restoring-division step
// Resolves quotient bit BIT: compare the shifted remainder against the
// divisor, subtract when it fits, shift the bit into the quotient.
// ----------------------------------------------------------------------------
module srd_stage #(
	parameter int WIDTH = srd_pkg::WIDTH_DEF,
	parameter int BIT   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WIDTH-1:0]    in_rem,
	input  logic [WIDTH-1:0]    in_den,
	input  logic [WIDTH-1:0]    in_quo,
	input  srd_pkg::srd_flags_t in_flags,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WIDTH-1:0]    out_rem,
	output logic [WIDTH-1:0]    out_den,
	output logic [WIDTH-1:0]    out_quo,
	output srd_pkg::srd_flags_t out_flags
);

	logic             fits;
	logic [WIDTH-1:0] rem_next;

	logic                valid_s1;
	logic [WIDTH-1:0]    rem_s1;
	logic [WIDTH-1:0]    den_s1;
	logic [WIDTH-1:0]    quo_s1;
	srd_pkg::srd_flags_t flags_s1;

	// when the divisor fits, (den << BIT) <= rem, so the truncated shift is exact
	assign fits     = (in_rem >> BIT) >= in_den;
	assign rem_next = fits ? (in_rem - (in_den << BIT)) : in_rem;

	// hold while this stage is full and the next stage is full and stalled
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s1   <= rem_next;
			den_s1   <= in_den;
			quo_s1   <= {in_quo[WIDTH-2:0], fits};
			flags_s1 <= in_flags;
		end
	end

	assign out_valid = valid_s1;
	assign out_rem   = rem_s1;
	assign out_den   = den_s1;
	assign out_quo   = quo_s1;
	assign out_flags = flags_s1;

endmodule

[design/signed_restoring_divider.sv]
// Throughput: one word per cycle while out_ready does not stall the output;
//   each of the WIDTH restoring steps owns a register stage, with an
//   operand-prep stage in front and a sign-fix stage behind, so the figure
//   is set by one WIDTH-bit compare and subtract.
// Reset: arst_n clears every stage valid bit at once; data registers keep
//   whatever they hold and are ignored until written.
// ----------------------------------------------------------------------------
// signed_restoring_divider: pipelined signed integer divider
// Quotient truncates toward zero. A zero divisor, and the most negative value
// over minus one, both give the largest positive value.
// ----------------------------------------------------------------------------
module signed_restoring_divider #(
	parameter int WIDTH = srd_pkg::WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [WIDTH-1:0] numerator,
	input  logic signed [WIDTH-1:0] denominator,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [WIDTH-1:0] quotient
);

	localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] MIN_NEG = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] ALL_ONE = {WIDTH{1'b1}};

	// ------------------------------------------------------------------
	// Operand prep: take magnitudes, flag the saturating cases.
	// ------------------------------------------------------------------
	logic                n_neg;
	logic                d_neg;
	logic [WIDTH-1:0]    n_mag;
	logic [WIDTH-1:0]    d_mag;
	srd_pkg::srd_flags_t prep_flags;

	assign n_neg = numerator[WIDTH-1];
	assign d_neg = denominator[WIDTH-1];
	// the most negative value maps onto 2^(WIDTH-1), which still fits unsigned
	assign n_mag = n_neg ? (~numerator + 1'b1) : numerator;
	assign d_mag = d_neg ? (~denominator + 1'b1) : denominator;

	always_comb begin
		prep_flags.neg = n_neg ^ d_neg;
		prep_flags.sat = (denominator == '0) ||
		                 ((numerator == MIN_NEG) && (denominator == ALL_ONE));
	end

	// Chain links: index 0 feeds the first step, index WIDTH leaves the last.
	logic                chain_valid [0:WIDTH];
	logic                chain_ready [0:WIDTH];
	logic [WIDTH-1:0]    chain_rem   [0:WIDTH];
	logic [WIDTH-1:0]    chain_den   [0:WIDTH];
	logic [WIDTH-1:0]    chain_quo   [0:WIDTH];
	srd_pkg::srd_flags_t chain_flags [0:WIDTH];

	logic                valid_s0;
	logic [WIDTH-1:0]    rem_s0;
	logic [WIDTH-1:0]    den_s0;
	srd_pkg::srd_flags_t flags_s0;

	// take a new word whenever the prep register is empty or draining
	assign in_ready = !valid_s0 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (in_ready) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s0   <= n_mag;
			den_s0   <= d_mag;
			flags_s0 <= prep_flags;
		end
	end

	assign chain_valid[0] = valid_s0;
	assign chain_rem[0]   = rem_s0;
	assign chain_den[0]   = den_s0;
	assign chain_quo[0]   = '0;
	assign chain_flags[0] = flags_s0;

	// ------------------------------------------------------------------
	// Restoring steps: stage k resolves quotient bit WIDTH-1-k, top bit
	// first. Each stage stalls only when it is full and its successor is full and stalled.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < WIDTH; k++) begin : g_step
		srd_stage #(
			.WIDTH (WIDTH),
			.BIT   (WIDTH - 1 - k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_rem    (chain_rem[k]),
			.in_den    (chain_den[k]),
			.in_quo    (chain_quo[k]),
			.in_flags  (chain_flags[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_rem   (chain_rem[k+1]),
			.out_den   (chain_den[k+1]),
			.out_quo   (chain_quo[k+1]),
			.out_flags (chain_flags[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Sign fix and output register. The final remainder and divisor are
	// dropped here; only the quotient and flags matter.
	// ------------------------------------------------------------------
	logic             valid_q;
	logic [WIDTH-1:0] quotient_q;
	logic [WIDTH-1:0] quo_fixed;
	logic             unused_tail;

	// negating 2^(WIDTH-1) wraps to the most negative value, which is exact
	always_comb begin
		if (chain_flags[WIDTH].sat) begin
			quo_fixed = MAX_POS;
		end else if (chain_flags[WIDTH].neg) begin
			quo_fixed = ~chain_quo[WIDTH] + 1'b1;
		end else begin
			quo_fixed = chain_quo[WIDTH];
		end
	end

	assign unused_tail = ^{chain_rem[WIDTH], chain_den[WIDTH]};

	// advance while the output slot is empty or its word is being taken
	assign chain_ready[WIDTH] = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (chain_ready[WIDTH]) begin
			valid_q <= chain_valid[WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[WIDTH] && chain_ready[WIDTH]) begin
			quotient_q <= quo_fixed ^ {WIDTH{unused_tail & 1'b0}};
		end
	end

	assign out_valid = valid_q;
	assign quotient  = quotient_q;

endmodule
